FILE: hdl/mmf_pkg.sv
package mmf_pkg;

	typedef enum logic [0:0] {
		REQ_STORE = 1'b0,
		REQ_READ  = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		CFG_ROWS     = 3'd0,
		CFG_COLS     = 3'd1,
		CFG_RADIUS   = 3'd2,
		CFG_CIRCULAR = 3'd3,
		CFG_ZMISS    = 3'd4,
		CFG_FRAC     = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	localparam int unsigned FRAC_ONE = 256;

	// Control strobes from the window walker to the accumulator.
	typedef struct packed {
		logic first;
		logic sample;
		logic last;
	} walk_ctl_t;

endpackage

FILE: hdl/mmf_ram.sv
module mmf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/mmf_hh.sv
// Circle half-heights: one floor(sqrt(r*r - d*d)) search step per cycle.
module mmf_hh
	import mmf_pkg::*;
#(
	parameter int unsigned MAX_RADIUS = 7,
	localparam int unsigned RB = $clog2(MAX_RADIUS + 1),
	localparam int unsigned NH = MAX_RADIUS + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RB-1:0] r,
	output logic          busy,
	output logic [RB-1:0] hh [NH]
);

	localparam int unsigned SB = 2 * RB + 1;

	logic [RB-1:0]   d_q;
	logic [RB-1:0]   s_q;
	logic            busy_q;
	logic [RB-1:0]   hh_q [NH];
	logic [RB:0]     s1;
	logic [SB-1:0]   sq;
	logic [SB-1:0]   lim;
	logic            grow;

	assign s1   = {1'b0, s_q} + 1'b1;
	assign sq   = SB'(s1) * SB'(s1);
	assign lim  = SB'(r) * SB'(r) - SB'(d_q) * SB'(d_q);
	assign grow = (d_q <= r) && (sq <= lim) && (s1 <= (RB+1)'(r));
	assign busy = busy_q;
	assign hh   = hh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			d_q    <= '0;
			s_q    <= '0;
			for (int i = 0; i < NH; i++) hh_q[i] <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			d_q    <= '0;
			s_q    <= '0;
		end else if (busy_q) begin
			if (grow) begin
				s_q <= s1[RB-1:0];
			end else begin
				hh_q[d_q] <= s_q;
				s_q       <= '0;
				if (d_q == RB'(MAX_RADIUS)) busy_q <= 1'b0;
				else d_q <= d_q + 1'b1;
			end
		end
	end

endmodule

FILE: hdl/mmf_acc.sv
// Window minimum and valid/total counts, with the quorum test at the end.
module mmf_acc
	import mmf_pkg::*;
#(
	parameter int unsigned PIXEL_BITS = 16,
	parameter int unsigned CB = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  walk_ctl_t             ctl,
	input  logic [PIXEL_BITS-1:0] pix,
	input  logic                  zmiss,
	input  logic [8:0]            frac,
	output logic                  done,
	output logic [15:0]           filtered,
	output logic                  below_quorum
);

	logic [CB-1:0]         total_q, valid_q;
	logic [PIXEL_BITS-1:0] min_q;
	logic                  fin_s1;
	logic                  skip;
	logic [CB+8:0]         lhs, rhs;

	assign skip = zmiss && (pix == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			valid_q <= '0;
			min_q   <= '1;
			fin_s1  <= 1'b0;
		end else begin
			fin_s1 <= ctl.last;
			if (ctl.first) begin
				total_q <= '0;
				valid_q <= '0;
				min_q   <= '1;
			end else if (ctl.sample) begin
				total_q <= total_q + 1'b1;
				if (!skip) begin
					valid_q <= valid_q + 1'b1;
					if (pix < min_q) min_q <= pix;
				end
			end
		end
	end

	assign lhs = (CB+9)'(valid_q) * (CB+9)'(FRAC_ONE) + (CB+9)'(total_q) * (CB+9)'(frac);
	assign rhs = (CB+9)'(total_q) * (CB+9)'(FRAC_ONE);
	assign done = fin_s1;
	assign below_quorum = (valid_q == '0) || (lhs < rhs);
	assign filtered = below_quorum ? 16'd0 : 16'(min_q);

endmodule

FILE: hdl/masked_min_filter_2d_core.sv
// Masked 2-D minimum filter over a stored image.
// Channels: s_axis (requests), m_axis (results), cfg (register writes).
// A store request (tuser = 0) writes one pixel into the pixel memory and
// produces no result. A read request (tuser = 1) walks the clipped square
// or circular window column by column, one memory read per cycle, and
// returns the minimum together with below_quorum. A read passes through the
// walk, drain and done states before the block is idle again and takes the
// next request; the single read port of the pixel memory sets the walk length.
// One request is in work at a time; the finished result sits in an output
// register, so the next request is taken while the result waits for
// m_axis_tready.
// If the receiver stalls with a result still held, the next read waits at
// the walk end until the output register is free.
// Reset loads rows 64, cols 64, radius 1, square window, no missing data,
// zero missing fraction, and rebuilds the circle half-heights; during that
// time no request is accepted. Pixel contents are not
// cleared; read only pixels that were written.
// Writing radius rebuilds the half-heights the same way.
module masked_min_filter_2d_core
	import mmf_pkg::*;
#(
	parameter int unsigned MAX_ROWS   = 64,
	parameter int unsigned MAX_COLS   = 64,
	parameter int unsigned MAX_RADIUS = 7,
	parameter int unsigned PIXEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // row[5:0], col[11:6], pixel[27:12], zero pad
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // filtered[15:0]
	output logic        m_axis_tuser,  // below_quorum
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int unsigned RB = $clog2(MAX_RADIUS + 1);
	localparam int unsigned NH = MAX_RADIUS + 1;
	localparam int unsigned RWB = $clog2(MAX_ROWS);
	localparam int unsigned CWB = $clog2(MAX_COLS);
	localparam int unsigned RW = (RWB < 1) ? 1 : RWB;
	localparam int unsigned CW = (CWB < 1) ? 1 : CWB;
	localparam int unsigned AW = $clog2(MAX_ROWS * MAX_COLS) < 1 ? 1
		: $clog2(MAX_ROWS * MAX_COLS);
	localparam int unsigned CB = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1) + 1);
	// Signed coordinate width: covers -MAX_RADIUS .. 63+MAX_RADIUS.
	localparam int unsigned SW = 9;

	// Configuration registers.
	logic [6:0] rows_q, cols_q;
	logic [2:0] radius_q;
	logic       circ_q, zmiss_q;
	logic [8:0] frac_q;

	logic        hh_busy;
	logic [RB-1:0] hh [NH];
	logic        cfg_fire, in_fire, out_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= 7'd64;
			cols_q   <= 7'd64;
			radius_q <= 3'd1;
			circ_q   <= 1'b0;
			zmiss_q  <= 1'b0;
			frac_q   <= 9'd0;
		end else if (cfg_fire) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROWS:     rows_q   <= cfg_data[6:0];
				CFG_COLS:     cols_q   <= cfg_data[6:0];
				CFG_RADIUS:   radius_q <= cfg_data[2:0];
				CFG_CIRCULAR: circ_q   <= cfg_data[0];
				CFG_ZMISS:    zmiss_q  <= cfg_data[0];
				CFG_FRAC:     frac_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective settings after clamping.
	logic [RB-1:0] r_eff;
	logic [10:0]   er, ec;
	logic [8:0]    frac_eff;

	assign r_eff = ({29'd0, radius_q} > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(radius_q);
	assign er = (rows_q == 7'd0) ? 11'd1
		: (({25'd0, rows_q} > MAX_ROWS) ? 11'(MAX_ROWS) : 11'(rows_q));
	assign ec = (cols_q == 7'd0) ? 11'd1
		: (({25'd0, cols_q} > MAX_COLS) ? 11'(MAX_COLS) : 11'(cols_q));
	assign frac_eff = (frac_q > 9'd256) ? 9'd256 : frac_q;

	// The rebuild starts the cycle after the write, when radius_q holds the new value.
	mmf_hh #(.MAX_RADIUS(MAX_RADIUS)) u_hh (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_fire && (cfg_idx_t'(cfg_index) == CFG_RADIUS)),
		.r      (r_eff),
		.busy   (hh_busy),
		.hh     (hh)
	);

	// Request fields.
	logic [5:0]  in_row, in_col;
	logic [15:0] in_pix;
	assign in_row = s_axis_tdata[5:0];
	assign in_col = s_axis_tdata[11:6];
	assign in_pix = s_axis_tdata[27:12];

	// Walker state.
	state_t state_q, state_d;
	logic signed [SW-1:0] crow_q, ccol_q, dx_q, dy_q, h_q;
	logic signed [SW-1:0] r_s;
	logic signed [SW-1:0] y, c, h_next, dx_n;
	logic                 col_ok, row_ok, step_last;
	logic                 out_full_q;
	logic [2:0]           drain_q;

	assign r_s = SW'(r_eff);
	assign c = ccol_q + dx_q;
	assign y = crow_q + dy_q;
	assign col_ok = (c >= 0) && (c < $signed({1'b0, ec[SW-2:0]}));
	assign row_ok = (y >= 0) && (y < $signed({1'b0, er[SW-2:0]}));
	assign step_last = (dx_q == r_s) && (dy_q >= h_q);
	assign dx_n = dx_q + SW'(1);
	always_comb begin
		logic [SW-1:0] adx;
		adx = dx_n[SW-1] ? -dx_n : dx_n;
		h_next = circ_q ? SW'(hh[adx[RB-1:0]]) : r_s;
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !hh_busy;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// Memory.
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [PIXEL_BITS-1:0] ram_rdata;

	assign ram_we = in_fire && (req_t'(s_axis_tuser) == REQ_STORE)
		&& ({26'd0, in_row} < MAX_ROWS) && ({26'd0, in_col} < MAX_COLS);
	assign ram_waddr = AW'(in_row) * AW'(MAX_COLS) + AW'(in_col);
	assign ram_raddr = AW'(y[RW-1:0]) * AW'(MAX_COLS) + AW'(c[CW-1:0]);

	mmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_ROWS * MAX_COLS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_pix[PIXEL_BITS-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_fire && req_t'(s_axis_tuser) == REQ_READ) state_d = ST_WALK;
			ST_WALK:  if (step_last) state_d = ST_DRAIN;
			ST_DRAIN: if (drain_q == 3'd2 && (!out_full_q || out_fire)) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Walker control outputs.
	walk_ctl_t ctl_s1, ctl_d;
	always_comb begin
		ctl_d.first  = (state_q == ST_IDLE) && in_fire && req_t'(s_axis_tuser) == REQ_READ;
		ctl_d.sample = (state_q == ST_WALK) && col_ok && row_ok && (dy_q >= -h_q);
		ctl_d.last   = (state_q == ST_DRAIN) && drain_q == 3'd2 && (!out_full_q || out_fire);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctl_s1  <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			// Sample lines up with the registered memory read.
			ctl_s1.first  <= ctl_d.first;
			ctl_s1.sample <= ctl_d.sample;
			ctl_s1.last   <= 1'b0;
			if (state_q == ST_DRAIN) begin
				if (drain_q != 3'd2) drain_q <= drain_q + 1'b1;
			end else begin
				drain_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_d.first) begin
			crow_q <= SW'(in_row);
			ccol_q <= SW'(in_col);
			dx_q   <= -r_s;
			dy_q   <= circ_q ? -SW'(hh[r_eff]) : -r_s;
			h_q    <= circ_q ? SW'(hh[r_eff]) : r_s;
		end else if (state_q == ST_WALK && !step_last) begin
			if (dy_q >= h_q) begin
				dx_q <= dx_n;
				dy_q <= -h_next;
				h_q  <= h_next;
			end else begin
				dy_q <= dy_q + SW'(1);
			end
		end
	end

	walk_ctl_t acc_ctl;
	assign acc_ctl = '{first: ctl_s1.first, sample: ctl_s1.sample, last: ctl_d.last};

	logic        acc_done, acc_low;
	logic [15:0] acc_min;

	mmf_acc #(.PIXEL_BITS(PIXEL_BITS), .CB(CB)) u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (acc_ctl),
		.pix          (ram_rdata),
		.zmiss        (zmiss_q),
		.frac         (frac_eff),
		.done         (acc_done),
		.filtered     (acc_min),
		.below_quorum (acc_low)
	);

	// Output register: hold the result until the receiver takes it.
	logic [15:0] out_data_q;
	logic        out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (acc_done) begin
			out_full_q <= 1'b1;
		end else if (out_fire) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_done) begin
			out_data_q <= acc_min;
			out_user_q <= acc_low;
		end
	end

	assign m_axis_tvalid = out_full_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// A result is never loaded over one still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		acc_done |-> !out_full_q || $past(out_fire))
		else $error("result overwritten");

	// No request is taken while the walker is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("request taken during walk");

	// A window read reaches the done state only after the strobe that ends it in a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> $past(ctl_d.last))
		else $error("walk ended without result");

endmodule

FILE: tb/sv/masked_min_filter_2d_core_test.sv
module masked_min_filter_2d_core_test;
	import mmf_pkg::*;

	localparam int NROW = 64;
	localparam int NCOL = 64;
	localparam int RMAX = 7;
	localparam int FILL = 16;
	localparam int STALL_LIMIT = 20000;

	// Result as the block reports it.
	typedef struct packed {
		logic [15:0] filtered;
		logic        below_quorum;
	} min_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // row[5:0], col[11:6], pixel[27:12], zero pad
	logic        s_axis_tuser = 1'b0; // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // filtered[15:0]
	logic        m_axis_tuser;        // below_quorum
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;

	// Shadow of the block: pixel memory, written flags, registers.
	logic [15:0] pix_mem [NROW*NCOL];
	bit          pix_written [NROW*NCOL];
	int unsigned cur_rows, cur_cols, cur_radius, cur_circ, cur_zmiss, cur_frac;
	min_result_t expected_minima [$];

	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;     // long receiver hold-off request
	int mismatches;
	int idle_cycles;
	bit timed_out;

	masked_min_filter_2d_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Integer square root, floor.
	function automatic int isqrt(int v);
		int s;
		s = 0;
		while ((s + 1) * (s + 1) <= v) s++;
		return s;
	endfunction

	// Compute the masked window minimum the block should return.
	function automatic min_result_t window_minimum(int row, int col);
		int er, ec, r, h, c, y, total, valid;
		int unsigned minv, frac;
		logic [15:0] v;
		min_result_t res;
		er = (cur_rows == 0) ? 1 : (cur_rows > NROW ? NROW : cur_rows);
		ec = (cur_cols == 0) ? 1 : (cur_cols > NCOL ? NCOL : cur_cols);
		r = (cur_radius > RMAX) ? RMAX : cur_radius;
		frac = (cur_frac > FRAC_ONE) ? FRAC_ONE : cur_frac;
		total = 0;
		valid = 0;
		minv = 32'hFFFF_FFFF;
		for (int dx = -r; dx <= r; dx++) begin
			c = col + dx;
			if (c < 0 || c >= ec) continue;
			h = cur_circ ? isqrt(r * r - dx * dx) : r;
			for (int dy = -h; dy <= h; dy++) begin
				y = row + dy;
				if (y < 0 || y >= er) continue;
				v = pix_mem[y * NCOL + c];
				total++;
				if (cur_zmiss && v == 0) continue;
				valid++;
				if (v < minv) minv = v;
			end
		end
		if (valid == 0 || FRAC_ONE * valid + frac * total < FRAC_ONE * total) begin
			res.filtered = '0;
			res.below_quorum = 1'b1;
		end else begin
			res.filtered = minv[15:0];
			res.below_quorum = 1'b0;
		end
		return res;
	endfunction

	// True when every pixel in the read window has been stored.
	function automatic bit window_written(int row, int col);
		int er, ec, r, h, c, y;
		er = (cur_rows == 0) ? 1 : (cur_rows > NROW ? NROW : cur_rows);
		ec = (cur_cols == 0) ? 1 : (cur_cols > NCOL ? NCOL : cur_cols);
		r = (cur_radius > RMAX) ? RMAX : cur_radius;
		for (int dx = -r; dx <= r; dx++) begin
			c = col + dx;
			if (c < 0 || c >= ec) continue;
			h = cur_circ ? isqrt(r * r - dx * dx) : r;
			for (int dy = -h; dy <= h; dy++) begin
				y = row + dy;
				if (y < 0 || y >= er) continue;
				if (!pix_written[y * NCOL + c]) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Offer one request and hold it until the block takes it; update the shadow.
	// Valid stays high afterwards; drain drops it when the sender stops.
	task automatic send_request(req_t kind, int row, int col, logic [15:0] pixel);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {4'b0, pixel, col[5:0], row[5:0]};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (kind == REQ_STORE) begin
			pix_mem[row * NCOL + col] = pixel;
			pix_written[row * NCOL + col] = 1'b1;
		end else begin
			expected_minima.push_back(window_minimum(row, col));
		end
	endtask

	task automatic read_pixel(int row, int col);
		send_request(REQ_READ, row, col, 16'($urandom));
	endtask

	// Drop valid, wait for every outstanding result, then let the block settle.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_minima.size() != 0) @(posedge clk);
		repeat (240) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[8:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ROWS:     cur_rows = value & 7'h7F;
			CFG_COLS:     cur_cols = value & 7'h7F;
			CFG_RADIUS:   cur_radius = value & 3'h7;
			CFG_CIRCULAR: cur_circ = value & 1;
			CFG_ZMISS:    cur_zmiss = value & 1;
			CFG_FRAC:     cur_frac = value & 9'h1FF;
			default: ;
		endcase
		// Radius writes rebuild the half-heights; give the block time.
		repeat (30) @(posedge clk);
	endtask

	task automatic set_window(int unsigned rows, int unsigned cols, int unsigned radius,
			int unsigned circ, int unsigned zmiss, int unsigned frac);
		drain();
		write_register(CFG_ROWS, rows);
		write_register(CFG_COLS, cols);
		write_register(CFG_RADIUS, radius);
		write_register(CFG_CIRCULAR, circ);
		write_register(CFG_ZMISS, zmiss);
		write_register(CFG_FRAC, frac);
	endtask

	// Fill the top-left corner; reads stay clipped to it so no unwritten pixel is read.
	task automatic test_fill_memory;
		for (int r = 0; r < FILL; r++)
			for (int c = 0; c < FILL; c++)
				send_request(REQ_STORE, r, c, 16'($urandom_range(1, 65535)));
	endtask

	task automatic test_directed;
		// Extreme pixel values, zeros as missing data, corners.
		set_window(FILL, FILL, 1, 0, 0, 0);
		send_request(REQ_STORE, 0, 0, 16'hFFFF);
		send_request(REQ_STORE, FILL - 1, FILL - 1, 16'h0000);
		send_request(REQ_STORE, 1, 1, 16'h0000);
		read_pixel(0, 0);
		read_pixel(FILL - 1, FILL - 1);
		set_window(FILL, FILL, 7, 0, 1, 256);
		read_pixel(FILL - 1, FILL - 1);
		read_pixel(8, 8);
		set_window(FILL, FILL, 7, 1, 1, 0);
		read_pixel(1, 1);
		read_pixel(0, FILL - 1);
		// Radius 0, zero pixel alone: no valid pixel.
		set_window(1, 1, 0, 0, 1, 128);
		send_request(REQ_STORE, 0, 0, 16'h0000);
		read_pixel(0, 0);
		// Centre outside the configured image: empty window.
		read_pixel(40, 40);
		// Out-of-range register values; unused bits set.
		set_window(0, 127, 7, 3, 3, 511);
		read_pixel(0, 5);
		set_window(100, 0, 3, 1, 0, 300);
		for (int r = FILL; r < FILL + 8; r++)
			send_request(REQ_STORE, r, 0, 16'($urandom_range(1, 65535)));
		read_pixel(FILL + 4, 0);
	endtask

	// Random mix of stores and reads; a quarter of stored pixels are zero so quorum flips both ways.
	task automatic test_random(int count);
		int row, col;
		logic [15:0] pix;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(2) == 0) begin
				row = $urandom_range(63);
				col = $urandom_range(63);
				pix = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom);
				send_request(REQ_STORE, row, col, pix);
			end else begin
				row = $urandom_range(FILL + 3);
				col = $urandom_range(FILL + 3);
				read_pixel(row, col);
			end
		end
	endtask

	task automatic random_config;
		set_window($urandom_range(1, FILL), $urandom_range(1, FILL), $urandom_range(7),
			$urandom_range(1), $urandom_range(1), $urandom_range(256));
	endtask

	// Hold the receiver off while requests keep coming; the block must stall.
	task automatic test_backpressure;
		recv_hold = 1'b1;
		fork
			repeat (2000) @(posedge clk);
			test_random(12);
		join_any
		recv_hold = 1'b0;
		wait fork;
		drain();
	endtask

	// Receiver: random stalls, long hold-off on request.
	always @(posedge clk) begin
		if (recv_hold)
			m_axis_tready <= 1'b0;
		else if (recv_idle_pct > 0)
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		else
			m_axis_tready <= 1'b1;
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		min_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_minima.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result filtered=%h below_quorum=%b",
						m_axis_tdata, m_axis_tuser);
			end else begin
				exp_res = expected_minima.pop_front();
				if (m_axis_tdata !== exp_res.filtered
						|| m_axis_tuser !== exp_res.below_quorum) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%b, got %h/%b",
							exp_res.filtered, exp_res.below_quorum,
							m_axis_tdata, m_axis_tuser);
				end
			end
		end
	end

	// Watchdog: count cycles without any transaction.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cur_rows = 64;
		cur_cols = 64;
		cur_radius = 1;
		cur_circ = 0;
		cur_zmiss = 0;
		cur_frac = 0;
		for (int i = 0; i < NROW * NCOL; i++) begin
			pix_mem[i] = '0;
			pix_written[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (40) @(posedge clk);

		test_fill_memory();
		test_directed();

		send_idle_pct = 19;
		recv_idle_pct = 74;
		set_window(FILL, FILL, 1, 0, 0, 0);
		test_random(60);
		random_config();
		test_backpressure();

		send_idle_pct = 74;
		recv_idle_pct = 19;
		set_window(FILL, FILL, 0, 1, 1, 256);
		test_random(50);
		random_config();
		test_random(50);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_window(FILL, FILL, 7, 1, 1, 64);
		test_random(50);
		random_config();
		test_random(50);
		drain();

		if (mismatches == 0 && expected_minima.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
